[rtl/gbn_pkg.sv]
// gbn_pkg: types, codes and constants of the go-back-n sender
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package gbn_pkg;

  // sequence and window sizing
  localparam int unsigned SEQ_SPACE    = 1024;
  localparam int unsigned WINDOW_MAX   = 64;
  localparam int unsigned BUFFER_DEPTH = 1000;

  localparam int CNT_W  = 11;  // base, next and queued counters
  localparam int WEND_W = 12;  // base plus window
  localparam int SEQ_W  = 10;
  localparam int WIN_W  = 7;
  localparam int SUM_W  = 15;  // checksum arithmetic

  localparam logic [SEQ_W-1:0] SEQ_MASK   = SEQ_W'(SEQ_SPACE - 1);
  localparam logic [WIN_W-1:0] WIN_RESET  = WIN_W'(8);
  localparam logic [WIN_W-1:0] WIN_LIMIT  = WIN_W'(WINDOW_MAX);
  localparam logic [CNT_W-1:0] BUF_LIMIT  = CNT_W'(BUFFER_DEPTH);

  // event kinds
  localparam logic [1:0] KIND_MSG     = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // timer actions
  localparam logic [1:0] TMR_NONE    = 2'd0;
  localparam logic [1:0] TMR_START   = 2'd1;
  localparam logic [1:0] TMR_STOP    = 2'd2;
  localparam logic [1:0] TMR_RESTART = 2'd3;

  // result status codes
  localparam logic [2:0] STAT_SENT    = 3'd0;
  localparam logic [2:0] STAT_NOTHING = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_BAD_SUM = 3'd3;
  localparam logic [2:0] STAT_OUT_WIN = 3'd4;
  localparam logic [2:0] STAT_NOT_BASE = 3'd5;

  // input word as held by the datapath
  typedef struct packed {
    logic [1:0]        kind;
    logic [SEQ_W-1:0]  ack_seq;
    logic [SEQ_W-1:0]  ack_num;
    logic signed [13:0] ack_checksum;
    logic signed [12:0] ack_payload_sum;
  } in_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch;  // take the input word
    logic emit;   // load one result word and commit its state update
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;   // output register can take a word
    logic final_step;  // the result under way is the last of its item
  } dp_sts_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

endpackage

[rtl/gbn_if.sv]
// gbn_if: valid/ready channel interfaces for the go-back-n sender
// depends on gbn_pkg for field widths
`timescale 1ns / 1ps

interface gbn_in_if import gbn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [SEQ_W-1:0]   ack_seq;
  logic [SEQ_W-1:0]   ack_num;
  logic signed [13:0] ack_checksum;
  logic signed [12:0] ack_payload_sum;

  modport source (output valid, kind, ack_seq, ack_num, ack_checksum, ack_payload_sum,
                  input ready);
  modport sink (input valid, kind, ack_seq, ack_num, ack_checksum, ack_payload_sum,
                output ready);
endinterface

interface gbn_out_if import gbn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             send_valid;
  logic [SEQ_W-1:0] send_seq;
  logic [1:0]       timer_action;
  logic [2:0]       status;
  logic             last;

  modport source (output valid, send_valid, send_seq, timer_action, status, last,
                  input ready);
  modport sink (input valid, send_valid, send_seq, timer_action, status, last,
                output ready);
endinterface

interface gbn_cfg_if import gbn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] win_len;

  modport source (output valid, win_len, input ready);
  modport sink (input valid, win_len, output ready);
endinterface

[rtl/gbn_ctrl.sv]
// gbn_ctrl: two-state controller sequencing one input word at a time
// depends on gbn_pkg; drives the datapath through dp_cmd_t
`timescale 1ns / 1ps

module gbn_ctrl import gbn_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = rst_n;
        cmd.latch = in_valid && rst_n;
        if (cmd.latch) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.emit = sts.slot_free;
        if (sts.slot_free && sts.final_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/gbn_dp.sv]
// gbn_dp: window counters, event evaluation and output register
// depends on gbn_pkg and gbn_if; commanded by gbn_ctrl
`timescale 1ns / 1ps

module gbn_dp import gbn_pkg::*; #(
  parameter int unsigned WIN_MAX = WINDOW_MAX
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dp_cmd_t       cmd,
  output dp_sts_t       sts,
  input  in_item_t      in_item,
  gbn_cfg_if.sink       cfg_chan,
  gbn_out_if.source     out_chan
);

  localparam logic [WIN_W-1:0] WIN_CAP = WIN_W'(WIN_MAX);

  // window state
  logic [WIN_W-1:0] win_size_r;
  logic [CNT_W-1:0] base_r, base_nxt;
  logic [CNT_W-1:0] nts_r, nts_nxt;
  logic [CNT_W-1:0] qc_r, qc_nxt;
  logic [CNT_W-1:0] iter_r;
  in_item_t         item_r;

  // output register
  logic             out_valid_r;
  logic             send_valid_r;
  logic [SEQ_W-1:0] send_seq_r;
  logic [1:0]       timer_r;
  logic [2:0]       status_r;
  logic             last_r;

  // result of the current step
  logic             res_valid;
  logic [CNT_W-1:0] res_seq;
  logic [1:0]       res_timer;
  logic [2:0]       res_status;
  logic             res_last;

  logic [WIN_W-1:0]  win_eff;
  logic [WEND_W-1:0] wend;
  logic [CNT_W-1:0]  qc_inc;
  logic [SUM_W-1:0]  ack_sum;
  logic [CNT_W-1:0]  anum_ext;
  logic [CNT_W-1:0]  new_base;
  logic [CNT_W-1:0]  nts_ack;
  logic [WEND_W-1:0] wend_ack;
  logic [CNT_W-1:0]  iter_inc;
  logic              iter_ok;
  logic              iter_next_ok;

  // effective window: zero acts as one, oversize clamps
  always_comb begin
    if (win_size_r == '0) begin
      win_eff = WIN_W'(1);
    end else if (win_size_r > WIN_CAP) begin
      win_eff = WIN_CAP;
    end else begin
      win_eff = win_size_r;
    end
  end

  assign wend     = WEND_W'(base_r) + WEND_W'(win_eff);
  assign qc_inc   = qc_r + CNT_W'(1);
  assign ack_sum  = SUM_W'(item_r.ack_seq) + SUM_W'(item_r.ack_num)
                  + SUM_W'(item_r.ack_payload_sum);
  assign anum_ext = CNT_W'(item_r.ack_num);
  assign new_base = anum_ext + CNT_W'(1);
  assign nts_ack  = (nts_r < new_base) ? new_base : nts_r;
  assign wend_ack = WEND_W'(new_base) + WEND_W'(win_eff);
  assign iter_inc = iter_r + CNT_W'(1);

  // retransmit walk bounds
  assign iter_ok      = (iter_r < nts_r) && (WEND_W'(iter_r) < wend) && (iter_r < qc_r);
  assign iter_next_ok = (iter_inc < nts_r) && (WEND_W'(iter_inc) < wend)
                      && (iter_inc < qc_r);

  // event evaluation
  always_comb begin
    res_valid  = 1'b0;
    res_seq    = '0;
    res_timer  = TMR_NONE;
    res_status = STAT_NOTHING;
    res_last   = 1'b1;
    base_nxt   = base_r;
    nts_nxt    = nts_r;
    qc_nxt     = qc_r;
    case (item_r.kind)
      KIND_MSG: begin
        if (qc_r >= BUF_LIMIT) begin
          res_status = STAT_FULL;
        end else begin
          qc_nxt = qc_inc;
          if ((WEND_W'(nts_r) < wend) && (nts_r < qc_inc)) begin
            res_valid  = 1'b1;
            res_seq    = nts_r;
            res_timer  = (base_r == nts_r) ? TMR_START : TMR_NONE;
            res_status = STAT_SENT;
            nts_nxt    = nts_r + CNT_W'(1);
          end
        end
      end
      KIND_ACK: begin
        if (ack_sum != SUM_W'(item_r.ack_checksum)) begin
          res_status = STAT_BAD_SUM;
        end else if ((anum_ext < base_r) || (WEND_W'(anum_ext) >= wend)) begin
          res_status = STAT_OUT_WIN;
        end else if ((anum_ext != base_r) || (base_r >= qc_r)) begin
          res_status = STAT_NOT_BASE;
        end else begin
          base_nxt = new_base;
          nts_nxt  = nts_ack;
          if ((WEND_W'(nts_ack) < wend_ack) && (nts_ack < qc_r)) begin
            res_valid  = 1'b1;
            res_seq    = nts_ack;
            res_timer  = TMR_RESTART;
            res_status = STAT_SENT;
            nts_nxt    = nts_ack + CNT_W'(1);
          end else if (nts_ack > new_base) begin
            res_timer = TMR_RESTART;
          end else begin
            res_timer = TMR_STOP;
          end
        end
      end
      KIND_TIMEOUT: begin
        if (iter_ok) begin
          res_valid  = 1'b1;
          res_seq    = iter_r;
          res_status = STAT_SENT;
          res_last   = !iter_next_ok;
          res_timer  = iter_next_ok ? TMR_NONE : TMR_START;
        end else begin
          res_timer = TMR_START;
        end
      end
      default: begin
        res_status = STAT_NOTHING;
      end
    endcase
  end

  assign sts.slot_free  = !out_valid_r || out_chan.ready;
  assign sts.final_step = res_last;

  // control state: window, counters, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r  <= WIN_RESET;
      base_r      <= '0;
      nts_r       <= '0;
      qc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        win_size_r <= cfg_chan.win_len;
      end
      if (cmd.emit) begin
        base_r      <= base_nxt;
        nts_r       <= nts_nxt;
        qc_r        <= qc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input word, walk index and output word
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
      iter_r <= base_r;
    end else if (cmd.emit) begin
      iter_r <= iter_inc;
    end
    if (cmd.emit) begin
      send_valid_r <= res_valid;
      send_seq_r   <= res_valid ? (res_seq[SEQ_W-1:0] & SEQ_MASK) : '0;
      timer_r      <= res_timer;
      status_r     <= res_status;
      last_r       <= res_last;
    end
  end

  assign cfg_chan.ready        = rst_n;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.send_valid   = send_valid_r;
  assign out_chan.send_seq     = send_seq_r;
  assign out_chan.timer_action = timer_r;
  assign out_chan.status       = status_r;
  assign out_chan.last         = last_r;

endmodule

[rtl/go_back_n_sender.sv]
// go_back_n_sender: go-back-n sender control, top level
// depends on gbn_pkg, gbn_if, gbn_ctrl and gbn_dp
//
// Channels: in_chan takes one event word (message, ack or timer expiry);
// out_chan gives result words, the final one of each event with last set;
// cfg_chan writes the window length and is ready whenever reset is off,
// to be used only while the block is idle.
// Timing: an event is latched in the idle state; in the exec state its
// result words are loaded into the output register whenever that register
// is free. A timer expiry walks the outstanding numbers one per cycle
// through the single output register, pausing while out_chan stalls.
// The next event is taken once the final word of the previous one has
// been loaded, even while that word is still waiting on out_chan.
// Reset: the window length returns to 8, base, next and queued counts to
// zero, and the output register empties.
// Stalls: while out_chan.ready is low the word in the output register
// holds and the walk pauses until the register frees up.
`timescale 1ns / 1ps

module go_back_n_sender import gbn_pkg::*; #(
  parameter int unsigned WIN_MAX = WINDOW_MAX
) (
  input  logic     clk,
  input  logic     rst_n,
  gbn_in_if.sink   in_chan,
  gbn_out_if.source out_chan,
  gbn_cfg_if.sink  cfg_chan
);

  dp_cmd_t  cmd;
  dp_sts_t  sts;
  in_item_t in_item;

  // pack the input word
  assign in_item.kind            = in_chan.kind;
  assign in_item.ack_seq         = in_chan.ack_seq;
  assign in_item.ack_num         = in_chan.ack_num;
  assign in_item.ack_checksum    = in_chan.ack_checksum;
  assign in_item.ack_payload_sum = in_chan.ack_payload_sum;

  // controller
  gbn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  gbn_dp #(
    .WIN_MAX (WIN_MAX)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (in_item),
    .cfg_chan (cfg_chan),
    .out_chan (out_chan)
  );

`ifndef NO_ASSERTIONS
  // an accepted word keeps the input closed for the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input open right after an accepted word");

  // a word with nothing to send carries sequence zero
  a_seq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.send_valid) |-> (out_chan.send_seq == '0))
    else $error("send_seq nonzero without send_valid");

  // only a sent status carries a packet to transmit
  a_send_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.send_valid) |-> (out_chan.status == STAT_SENT))
    else $error("send_valid with a status other than sent");

  // the datapath never loads a word into a full, stalled output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |-> !cmd.emit)
    else $error("result word overwritten while stalled");
`endif

endmodule
